>>> hw/rtl/magnet_pull_trigger_detector_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the magnet pull trigger detector.
// Each macro expands to a concurrent assertion clocked on clk_i, or to nothing
// when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef MAGNET_PULL_TRIGGER_DETECTOR_CORE_ASSERT_SVH
`define MAGNET_PULL_TRIGGER_DETECTOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked only while the block is out of reset.
`define MPTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define MPTD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MPTD_ASSERT(lbl, prop, msg)
`define MPTD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/mptd_pkg.sv
// ----------------------------------------------------------------------------
// mptd_pkg
// Constants and types shared by the magnet pull trigger detector.
// ----------------------------------------------------------------------------
`default_nettype none

package mptd_pkg;

  // Samples in one segment; the window holds two segments plus the baseline.
  localparam int SEGMENT_LEN = 20;
  localparam int AXIS_WIDTH  = 16;
  localparam int CFG_WIDTH   = 16;

  localparam int WIN_DEPTH = 2 * SEGMENT_LEN + 1;
  localparam int SLOT_W    = $clog2(WIN_DEPTH);
  localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
  localparam int AGE_W     = $clog2(2 * SEGMENT_LEN);

  // Multiplier lane width covers an axis difference and a threshold.
  localparam int LANE_W   = (AXIS_WIDTH > CFG_WIDTH) ? AXIS_WIDTH + 1 : CFG_WIDTH + 1;
  localparam int SQ_W     = 2 * LANE_W - 2;
  localparam int SUM_W    = SQ_W + 2;
  localparam int THR_SQ_W = 2 * CFG_WIDTH;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 1'b1;

  localparam logic [CFG_WIDTH-1:0] LOW_RESET  = 16'd480;
  localparam logic [CFG_WIDTH-1:0] HIGH_RESET = 16'd2080;

  // One stored magnetometer sample.
  typedef struct packed {
    logic [AXIS_WIDTH-1:0] z;
    logic [AXIS_WIDTH-1:0] y;
    logic [AXIS_WIDTH-1:0] x;
  } sample_t;

endpackage

`default_nettype wire

>>> hw/rtl/magnet_pull_trigger_detector_core.sv
// ----------------------------------------------------------------------------
// magnet_pull_trigger_detector_core
// Detects a magnet pull from a sliding window of 3-axis magnetometer samples.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the in_valid_i/in_ready_o channel, one result per sample
// leaves on out_valid_o/out_ready_i. An all-zero sample is dropped and answered
// with all result flags low. Other samples go into a 41-entry ring memory.
// Once 40 samples are stored, one shared three-lane squaring unit walks the
// 40 oldest entries, one per cycle, against the newest sample, tracking the
// smallest squared distance of the first segment and the largest of the second.
// A dropped or stored-only sample goes straight to the result state; when the window
// is evaluated, the threshold squaring, the memory walk and the drain of the read
// pipeline come first. in_ready_o is low while a sample is in work, so items
// are taken one at a time.
// A finished result sits in an output register, so the next sample can be
// taken while it waits; a stalled receiver holds the block only when a second
// result is ready. Reset empties the window and loads the threshold defaults
// (480 and 2080); the memory contents are never cleared. Threshold writes go in
// through cfg_we_i, by the user only while the block is idle; it is not checked.
// ----------------------------------------------------------------------------
`default_nettype none

module magnet_pull_trigger_detector_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Sample channel
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [mptd_pkg::AXIS_WIDTH-1:0]    field_x_i,
  input  wire logic [mptd_pkg::AXIS_WIDTH-1:0]    field_y_i,
  input  wire logic [mptd_pkg::AXIS_WIDTH-1:0]    field_z_i,
  // Result channel
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic                                    sample_taken_o,
  output logic                                    window_ready_o,
  output logic                                    trigger_o,
  // Configuration write port
  input  wire logic                               cfg_we_i,
  input  wire logic [mptd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [mptd_pkg::CFG_WIDTH-1:0]     cfg_data_i
);

`include "magnet_pull_trigger_detector_core_assert.svh"

  localparam int SLOT_W = mptd_pkg::SLOT_W;
  localparam int FILL_W = mptd_pkg::FILL_W;
  localparam int AGE_W  = mptd_pkg::AGE_W;
  localparam int LANE_W = mptd_pkg::LANE_W;
  localparam int SQ_W   = mptd_pkg::SQ_W;
  localparam int SUM_W  = mptd_pkg::SUM_W;
  localparam int AW     = mptd_pkg::AXIS_WIDTH;
  localparam int CW     = mptd_pkg::CFG_WIDTH;

  localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(mptd_pkg::WIN_DEPTH);
  localparam logic [FILL_W-1:0] FILL_EVAL  = FILL_W'(2 * mptd_pkg::SEGMENT_LEN);
  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(mptd_pkg::WIN_DEPTH - 1);
  localparam logic [AGE_W-1:0]  AGE_LAST   = AGE_W'(2 * mptd_pkg::SEGMENT_LEN - 1);
  localparam logic [AGE_W-1:0]  AGE_SEG2   = AGE_W'(mptd_pkg::SEGMENT_LEN);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_THR   = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]                   state_q, state_d;
  logic [CW-1:0]                low_q, high_q;
  logic [FILL_W-1:0]            fill_q;
  logic [SLOT_W-1:0]            oldest_q;
  mptd_pkg::sample_t            smp_q;
  mptd_pkg::sample_t            in_smp;
  mptd_pkg::sample_t            win_mem [mptd_pkg::WIN_DEPTH];
  mptd_pkg::sample_t            rd_data_q;
  logic [SLOT_W-1:0]            rd_slot_q;
  logic [AGE_W-1:0]             age_q;
  logic                         rd_vld_q, rd_seg_q;
  logic                         sq_vld_q, sq_seg_q, sq_thr_q;
  logic [SQ_W-1:0]              sq_q [3];
  logic [SUM_W-1:0]             min_q, max_q;
  logic [mptd_pkg::THR_SQ_W-1:0] lo_sq_q, hi_sq_q;
  logic                         res_taken_q, res_ready_q, res_trig_q;
  logic                         out_vld_q, out_taken_q, out_ready_q, out_trig_q;

  logic                         accept;
  logic                         in_zero;
  logic                         win_full;
  logic [FILL_W:0]              wr_sum;
  logic [SLOT_W-1:0]            wr_slot;
  logic [FILL_W-1:0]            fill_new;
  logic [SLOT_W-1:0]            oldest_new;
  logic                         out_free;
  logic                         pipe_empty;
  logic                         hit;
  logic signed [LANE_W-1:0]     lane [3];
  logic signed [2*LANE_W-1:0]   prod [3];
  logic [SUM_W-1:0]             dist_sum;

  assign in_smp = '{z: field_z_i, y: field_y_i, x: field_x_i};

  // Handshake terms.
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign in_zero    = (field_x_i == '0) && (field_y_i == '0) && (field_z_i == '0);
  assign out_free   = !out_vld_q || out_ready_i;
  assign pipe_empty = !rd_vld_q && !sq_vld_q;

  // Ring update: a full window overwrites its oldest slot.
  assign win_full   = (fill_q == FILL_FULL);
  assign wr_sum     = (FILL_W + 1)'(oldest_q) + (FILL_W + 1)'(fill_q);
  assign wr_slot    = win_full ? oldest_q :
                      (wr_sum >= (FILL_W + 1)'(mptd_pkg::WIN_DEPTH)) ?
                      SLOT_W'(wr_sum - (FILL_W + 1)'(mptd_pkg::WIN_DEPTH)) :
                      SLOT_W'(wr_sum);
  assign fill_new   = win_full ? fill_q : fill_q + FILL_W'(1);
  assign oldest_new = !win_full ? oldest_q :
                      (oldest_q == SLOT_LAST) ? '0 : oldest_q + SLOT_W'(1);

  // Trigger decision once the walk has drained.
  assign hit = (min_q < SUM_W'(lo_sq_q)) && (max_q > SUM_W'(hi_sq_q));

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= mptd_pkg::LOW_RESET;
      high_q <= mptd_pkg::HIGH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mptd_pkg::REG_LOW_THRESHOLD:  low_q  <= cfg_data_i;
        mptd_pkg::REG_HIGH_THRESHOLD: high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_zero || (fill_new < FILL_EVAL)) ? ST_FIN : ST_THR;
        end
      end
      ST_THR:   state_d = ST_SCAN;
      ST_SCAN: begin
        if (age_q == AGE_LAST) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (pipe_empty) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control state: sequencer, window bookkeeping, read pipeline tags, result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      oldest_q    <= '0;
      age_q       <= '0;
      rd_slot_q   <= '0;
      rd_vld_q    <= 1'b0;
      rd_seg_q    <= 1'b0;
      sq_vld_q    <= 1'b0;
      sq_seg_q    <= 1'b0;
      sq_thr_q    <= 1'b0;
      res_taken_q <= 1'b0;
      res_ready_q <= 1'b0;
      res_trig_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ST_SCAN);
      rd_seg_q <= (age_q >= AGE_SEG2);
      sq_vld_q <= rd_vld_q || (state_q == ST_THR);
      sq_seg_q <= rd_seg_q;
      sq_thr_q <= (state_q == ST_THR);

      // Sample transfer: store it and note what the result will say.
      if (accept) begin
        res_taken_q <= !in_zero;
        res_ready_q <= !in_zero && (fill_new >= FILL_EVAL);
        res_trig_q  <= 1'b0;
        if (!in_zero) begin
          fill_q   <= fill_new;
          oldest_q <= oldest_new;
        end
      end

      // Walk starts at the oldest slot.
      if (state_q == ST_THR) begin
        age_q     <= '0;
        rd_slot_q <= oldest_q;
      end else if (state_q == ST_SCAN) begin
        age_q     <= age_q + AGE_W'(1);
        rd_slot_q <= (rd_slot_q == SLOT_LAST) ? '0 : rd_slot_q + SLOT_W'(1);
      end

      // Decision: a trigger empties the window.
      if (state_q == ST_DRAIN && pipe_empty) begin
        res_trig_q <= hit;
        if (hit) begin
          fill_q   <= '0;
          oldest_q <= '0;
        end
      end

      // Output register.
      if (state_q == ST_FIN && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && out_free) begin
      out_taken_q <= res_taken_q;
      out_ready_q <= res_ready_q;
      out_trig_q  <= res_trig_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign sample_taken_o = out_taken_q;
  assign window_ready_o = out_ready_q;
  assign trigger_o      = out_trig_q;

  // Window memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (accept && !in_zero) begin
      win_mem[wr_slot] <= in_smp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN) begin
      rd_data_q <= win_mem[rd_slot_q];
    end
  end

  // Baseline sample held for the walk.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q <= in_smp;
    end
  end

  // Shared squaring unit: thresholds first, then axis differences.
  always_comb begin
    if (state_q == ST_THR) begin
      lane[0] = $signed({{(LANE_W - CW){1'b0}}, low_q});
      lane[1] = $signed({{(LANE_W - CW){1'b0}}, high_q});
      lane[2] = '0;
    end else begin
      lane[0] = $signed({{(LANE_W - AW){rd_data_q.x[AW-1]}}, rd_data_q.x})
              - $signed({{(LANE_W - AW){smp_q.x[AW-1]}}, smp_q.x});
      lane[1] = $signed({{(LANE_W - AW){rd_data_q.y[AW-1]}}, rd_data_q.y})
              - $signed({{(LANE_W - AW){smp_q.y[AW-1]}}, smp_q.y});
      lane[2] = $signed({{(LANE_W - AW){rd_data_q.z[AW-1]}}, rd_data_q.z})
              - $signed({{(LANE_W - AW){smp_q.z[AW-1]}}, smp_q.z});
    end
    for (int k = 0; k < 3; k++) begin
      prod[k] = lane[k] * lane[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= prod[k][SQ_W-1:0];
    end
  end

  // Distance accumulation: minimum over the first segment, maximum over the second.
  assign dist_sum = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_THR) begin
      min_q <= '1;
      max_q <= '0;
    end else if (sq_vld_q) begin
      if (sq_thr_q) begin
        lo_sq_q <= sq_q[0][mptd_pkg::THR_SQ_W-1:0];
        hi_sq_q <= sq_q[1][mptd_pkg::THR_SQ_W-1:0];
      end else if (!sq_seg_q) begin
        if (dist_sum < min_q) min_q <= dist_sum;
      end else begin
        if (dist_sum > max_q) max_q <= dist_sum;
      end
    end
  end

  // Assertions.
  `MPTD_ASSERT(a_fill_bound, fill_q <= FILL_FULL, "window fill beyond depth")
  `MPTD_ASSERT(a_trig_needs_eval, out_valid_o && trigger_o |-> window_ready_o && sample_taken_o,
               "trigger reported without evaluation")
  `MPTD_ASSERT(a_busy_after_accept, accept |=> !in_ready_o, "ready right after a transfer")
  `MPTD_ASSERT(a_pipe_idle, state_q == ST_IDLE |-> pipe_empty, "walk pipeline busy while idle")
  `MPTD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> state_q == ST_IDLE && !out_vld_q,
                      "sequencer not idle in reset")

endmodule

`default_nettype wire

>>> verif/tb_magnet_pull_trigger_detector_core.sv
// ----------------------------------------------------------------------------
// Magnet pull trigger detector core testbench
// Drives magnetometer samples and threshold writes into the core and compares
// every result transfer with an in-bench model of the sliding window and its
// near/far distance test. It covers field extremes, threshold extremes and
// random pull gestures under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_magnet_pull_trigger_detector_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEGMENT_LEN = mptd_pkg::SEGMENT_LEN;
  localparam int AXIS_WIDTH  = mptd_pkg::AXIS_WIDTH;
  localparam int CFG_WIDTH   = mptd_pkg::CFG_WIDTH;
  localparam int CFG_IDX_W   = mptd_pkg::CFG_IDX_W;
  localparam int WIN_DEPTH   = mptd_pkg::WIN_DEPTH;
  localparam int SAMPLE_W    = 3 * AXIS_WIDTH;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = mptd_pkg::REG_LOW_THRESHOLD;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = mptd_pkg::REG_HIGH_THRESHOLD;
  localparam logic [CFG_WIDTH-1:0] LOW_RESET          = mptd_pkg::LOW_RESET;
  localparam logic [CFG_WIDTH-1:0] HIGH_RESET         = mptd_pkg::HIGH_RESET;

  typedef mptd_pkg::sample_t sample_t;
  typedef longint unsigned u64_t;

  // One result: the three flags the core reports for each sample.
  typedef struct packed {
    logic taken;
    logic ready;
    logic fired;
  } pull_flags_t;

  localparam int unsigned SETTLE_CYCLES = 2 * SEGMENT_LEN + 8;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [AXIS_WIDTH-1:0] field_x_i   = '0;
  logic [AXIS_WIDTH-1:0] field_y_i   = '0;
  logic [AXIS_WIDTH-1:0] field_z_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  sample_taken_o;
  logic                  window_ready_o;
  logic                  trigger_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_WIDTH-1:0]  cfg_data_i  = '0;

  // Model of the detector state.
  sample_t               ring_mem [WIN_DEPTH];
  int unsigned           fill_cnt  = 0;
  int unsigned           head_slot = 0;
  logic [CFG_WIDTH-1:0]  low_thr   = LOW_RESET;
  logic [CFG_WIDTH-1:0]  high_thr  = HIGH_RESET;

  pull_flags_t           pull_flags_q[$];
  int unsigned           flag_errors   = 0;
  int unsigned           stored_count  = 0;
  int unsigned           sender_idle_pct   = 16;
  int unsigned           receiver_idle_pct = 72;

  magnet_pull_trigger_detector_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .field_x_i      (field_x_i),
    .field_y_i      (field_y_i),
    .field_z_i      (field_z_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_taken_o (sample_taken_o),
    .window_ready_o (window_ready_o),
    .trigger_o      (trigger_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The run ends here if the core stops answering.
  initial begin
    #10_000_000;
    $display("tb_magnet_pull_trigger_detector_core NOT OK");
    $finish;
  end

  // Squared distance between two samples, exact.
  function automatic u64_t gap_sq(sample_t a, sample_t b);
    longint dx, dy, dz;
    dx = longint'($signed(a.x)) - longint'($signed(b.x));
    dy = longint'($signed(a.y)) - longint'($signed(b.y));
    dz = longint'($signed(a.z)) - longint'($signed(b.z));
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // Updates the window model with one sample and returns the flags it causes.
  function automatic pull_flags_t predict_pull(sample_t s);
    pull_flags_t r;
    sample_t     base;
    u64_t        near_min, far_max, d;
    r = '0;
    if (s == '0) return r;
    r.taken = 1'b1;
    if (fill_cnt > 2 * SEGMENT_LEN) begin
      head_slot = (head_slot + 1) % WIN_DEPTH;
      fill_cnt--;
    end
    ring_mem[(head_slot + fill_cnt) % WIN_DEPTH] = s;
    fill_cnt++;
    if (fill_cnt < 2 * SEGMENT_LEN) return r;
    r.ready  = 1'b1;
    base     = ring_mem[(head_slot + fill_cnt - 1) % WIN_DEPTH];
    near_min = '1;
    far_max  = '0;
    for (int unsigned i = 0; i < 2 * SEGMENT_LEN; i++) begin
      d = gap_sq(ring_mem[(head_slot + i) % WIN_DEPTH], base);
      if (i < SEGMENT_LEN && d < near_min) near_min = d;
      if (i >= SEGMENT_LEN && d > far_max) far_max = d;
    end
    if (near_min < u64_t'(low_thr) * u64_t'(low_thr) &&
        far_max > u64_t'(high_thr) * u64_t'(high_thr)) begin
      r.fired   = 1'b1;
      fill_cnt  = 0;
      head_slot = 0;
    end
    return r;
  endfunction

  function automatic sample_t mk_sample(logic [AXIS_WIDTH-1:0] x, y, z);
    sample_t s;
    s.x = x;
    s.y = y;
    s.z = z;
    return s;
  endfunction

  // Sample within +/- span of the center on every axis, wrapping at the width.
  function automatic sample_t jitter(sample_t c, int unsigned span);
    sample_t r;
    r.x = c.x + AXIS_WIDTH'(int'($urandom_range(2 * span)) - int'(span));
    r.y = c.y + AXIS_WIDTH'(int'($urandom_range(2 * span)) - int'(span));
    r.z = c.z + AXIS_WIDTH'(int'($urandom_range(2 * span)) - int'(span));
    return r;
  endfunction

  // Sample pushed away from the center by reach/2 to reach on every axis.
  function automatic sample_t pulled(sample_t c, int unsigned reach);
    sample_t r;
    int      off [3];
    for (int k = 0; k < 3; k++) begin
      off[k] = int'($urandom_range(reach, reach / 2));
      if ($urandom_range(1)) off[k] = -off[k];
    end
    r.x = c.x + AXIS_WIDTH'(off[0]);
    r.y = c.y + AXIS_WIDTH'(off[1]);
    r.z = c.z + AXIS_WIDTH'(off[2]);
    return r;
  endfunction

  // Receiver side: stall at random per cycle.
  initial begin
    forever begin
      @(posedge clk_i);
      out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  task automatic check_flag(string name, logic want, logic got);
    if (want !== got) begin
      flag_errors++;
      $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
    end
  endtask

  // Every result transfer is compared with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    pull_flags_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pull_flags_q.size() == 0) begin
        flag_errors++;
        $display("%0t: unexpected result, expected none, actual %b%b%b", $time,
                 sample_taken_o, window_ready_o, trigger_o);
      end else begin
        want = pull_flags_q.pop_front();
        check_flag("sample_taken", want.taken, sample_taken_o);
        check_flag("window_ready", want.ready, window_ready_o);
        check_flag("trigger", want.fired, trigger_o);
      end
    end
  end

  // Sends one sample and records its predicted flags once the transfer happens.
  // Valid stays high after the transfer unless the next call idles first.
  task automatic send_sample(sample_t s);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    field_x_i  <= s.x;
    field_y_i  <= s.y;
    field_z_i  <= s.z;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pull_flags_q.insert(pull_flags_q.size(), predict_pull(s));
    if (s != '0) stored_count++;
  endtask

  // Holds the sender until every predicted result has arrived and the core is idle.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pull_flags_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes both thresholds on back-to-back cycles; the core must be idle.
  task automatic program_thresholds(logic [CFG_WIDTH-1:0] lo, hi);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_LOW_THRESHOLD;
    cfg_data_i <= lo;
    @(posedge clk_i);
    low_thr     = lo;
    cfg_idx_i  <= REG_HIGH_THRESHOLD;
    cfg_data_i <= hi;
    @(posedge clk_i);
    high_thr    = hi;
    cfg_we_i   <= 1'b0;
  endtask

  // A quiet stretch near the base, a pull away from it, then a return.
  task automatic send_pull_gesture(sample_t base, int unsigned quiet_n, pull_n, tail_n,
                                   int unsigned spread, reach);
    for (int unsigned i = 0; i < quiet_n; i++) begin
      if ($urandom_range(24) == 0) send_sample('0);
      send_sample(jitter(base, spread));
    end
    for (int unsigned i = 0; i < pull_n; i++) send_sample(pulled(base, reach));
    for (int unsigned i = 0; i < tail_n; i++) send_sample(jitter(base, spread));
  endtask

  // Axis extremes, single bits and all-zero samples on a short window.
  task automatic test_field_extremes();
    send_sample('0);
    send_sample(mk_sample(16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_sample(mk_sample(16'h8000, 16'h8000, 16'h8000));
    send_sample(mk_sample(16'h8000, 16'h7FFF, 16'h0000));
    send_sample(mk_sample(16'h0000, 16'h0000, 16'h0001));
    send_sample(mk_sample(16'h0000, 16'h8000, 16'h0000));
    send_sample(mk_sample(16'h0001, 16'h0000, 16'h0000));
    send_sample('0);
    send_sample(mk_sample(16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_sample(mk_sample(16'h5555, 16'hAAAA, 16'h5555));
    send_sample(mk_sample(16'hAAAA, 16'h5555, 16'hAAAA));
  endtask

  // Full-scale swings between the most negative and most positive corners
  // under the extreme threshold settings and the reset defaults.
  task automatic test_threshold_extremes();
    logic [CFG_WIDTH-1:0] lo_set [5];
    logic [CFG_WIDTH-1:0] hi_set [5];
    sample_t              low_corner, high_corner;
    lo_set = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, LOW_RESET};
    hi_set = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, HIGH_RESET};
    low_corner  = mk_sample(16'h8000, 16'h8000, 16'h8000);
    high_corner = mk_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    for (int k = 0; k < 5; k++) begin
      settle_block();
      program_thresholds(lo_set[k], hi_set[k]);
      repeat (22) send_sample(low_corner);
      repeat (10) send_sample(high_corner);
      repeat (9) send_sample(low_corner);
    end
  endtask

  // Picks a new threshold pair, sometimes at the edges of the range.
  task automatic retune_thresholds();
    logic [CFG_WIDTH-1:0] lo, hi;
    case ($urandom_range(5))
      0: begin
        lo = '1;
        hi = '0;
      end
      1: begin
        lo = '0;
        hi = '1;
      end
      2: begin
        lo = LOW_RESET;
        hi = HIGH_RESET;
      end
      default: begin
        lo = CFG_WIDTH'($urandom_range(4000, 32));
        hi = CFG_WIDTH'($urandom_range(12000, lo));
      end
    endcase
    settle_block();
    program_thresholds(lo, hi);
  endtask

  // Mostly pull gestures shaped by the current thresholds, with noise bursts.
  task automatic test_random_gestures(int unsigned send_pct, recv_pct, item_n);
    int unsigned first_count;
    int unsigned round;
    int unsigned spread, reach;
    sample_t     base;
    sender_idle_pct   = send_pct;
    receiver_idle_pct = recv_pct;
    first_count       = stored_count;
    round             = 0;
    while (stored_count - first_count < item_n) begin
      if (round % 8 == 7) retune_thresholds();
      // Let the core drain completely before going on.
      if (round == 2) settle_block();
      base = sample_t'(SAMPLE_W'({$urandom(), $urandom()}));
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(12, 1)) begin
          if ($urandom_range(19) == 0) send_sample('0);
          else send_sample(sample_t'(SAMPLE_W'({$urandom(), $urandom()})));
        end
      end else begin
        spread = low_thr / 3;
        reach  = (2 * int'(high_thr) > 30000) ? 30000 : 2 * high_thr + 16;
        send_pull_gesture(base, $urandom_range(30, 5), $urandom_range(12, 1),
                          $urandom_range(12, 1), spread, reach);
      end
      round++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_threshold_extremes();
    test_random_gestures(16, 72, 480);
    test_random_gestures(72, 16, 480);
    test_random_gestures(0, 0, 480);

    settle_block();
    if (flag_errors == 0 && pull_flags_q.size() == 0) begin
      $display("tb_magnet_pull_trigger_detector_core OK");
    end else begin
      $display("tb_magnet_pull_trigger_detector_core NOT OK");
    end
    $finish;
  end

endmodule

>>> magnet_pull_trigger_detector_core.f
+incdir+hw/rtl
hw/rtl/mptd_pkg.sv
hw/rtl/magnet_pull_trigger_detector_core.sv
verif/tb_magnet_pull_trigger_detector_core.sv
